// ===== rtl/slpm_pkg.sv =====
// shared types for the scored list pick-max block
package slpm_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_PICK   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SWAP_A,
		S_SWAP_B,
		S_RESULT
	} state_t;

endpackage

// ===== rtl/scored_list_pick_max.sv =====
// scored list pick-max: entry table with iterative best-score scan and swap
//
// A table of up to MAX_ENTRIES (tag, signed score) entries held in one
// memory with a single write port and a single registered read port. Clear
// and append leave the block in its idle state, so it is ready again on the
// next cycle. A pick at a position below the entry count reads the entries
// from that position to the end through the read port, one per cycle,
// keeping the best score in a register with one signed compare (earliest
// entry wins on ties). It then swaps the winner into the named position
// through the write port when the winner is not already there; a pick at or
// beyond the count reports not found.
// The result sits in an output register; a further pick finishes its scan
// while an earlier result is still waiting and holds only at delivery.
// The store has no reset; only positions written by an append are scanned.
module scored_list_pick_max
	import slpm_pkg::*;
#(
	parameter int MAX_ENTRIES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [31:0]        entry_tag,
	input  logic signed [31:0] entry_score,
	input  logic [7:0]         start_position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic [31:0]        picked_tag
);

	localparam int AW = (MAX_ENTRIES > 2) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int PW = (CW > 8) ? CW : 8;

	logic [31:0]        tag_mem [MAX_ENTRIES];
	logic signed [31:0] score_mem [MAX_ENTRIES];

	state_t state_q, state_n;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      idx_q;
	logic [AW-1:0]      cmp_addr_q;
	logic [AW-1:0]      pos_q;
	logic [AW-1:0]      best_idx_q;
	logic [31:0]        best_tag_q;
	logic signed [31:0] best_score_q;
	logic [31:0]        held_tag_q;
	logic signed [31:0] held_score_q;
	logic               first_q;
	logic [31:0]        rd_tag_q;
	logic signed [31:0] rd_score_q;
	logic               res_found_q;
	logic [31:0]        res_tag_q;
	logic               out_valid_q;
	logic               found_q;
	logic [31:0]        picked_tag_q;

	logic               in_fire;
	logic               out_free;
	logic [PW-1:0]      pos_ext;
	logic [PW-1:0]      cnt_ext;
	logic               pos_hit;
	logic               take_best;
	logic               more;
	logic               we;
	logic [AW-1:0]      wa;
	logic [31:0]        wtag;
	logic signed [31:0] wscore;
	logic [AW-1:0]      ra;
	cmd_t               cmd;

	assign cmd       = cmd_t'(command);
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign pos_ext   = PW'(start_position);
	assign cnt_ext   = PW'(count_q);
	assign pos_hit   = pos_ext < cnt_ext;
	assign take_best = first_q || (rd_score_q > best_score_q);
	assign more      = idx_q < count_q;

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign picked_tag = picked_tag_q;

	// sequencer and memory port control
	always_comb begin
		state_n = state_q;
		we      = 1'b0;
		wa      = count_q[AW-1:0];
		wtag    = entry_tag;
		wscore  = entry_score;
		ra      = idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				ra = pos_ext[AW-1:0];
				if (in_fire) begin
					case (cmd)
						CMD_APPEND: begin
							we = (count_q < CW'(MAX_ENTRIES));
						end
						CMD_PICK: begin
							state_n = pos_hit ? S_SCAN : S_RESULT;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (!more) begin
					state_n = S_SWAP_A;
				end
			end
			S_SWAP_A: begin
				if (best_idx_q != pos_q) begin
					we      = 1'b1;
					wa      = pos_q;
					wtag    = best_tag_q;
					wscore  = best_score_q;
					state_n = S_SWAP_B;
				end else begin
					state_n = S_RESULT;
				end
			end
			S_SWAP_B: begin
				we      = 1'b1;
				wa      = best_idx_q;
				wtag    = held_tag_q;
				wscore  = held_score_q;
				state_n = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (we) begin
			tag_mem[wa]   <= wtag;
			score_mem[wa] <= wscore;
		end
		rd_tag_q   <= tag_mem[ra];
		rd_score_q <= score_mem[ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
			first_q     <= 1'b0;
		end else begin
			if (in_fire && cmd == CMD_CLEAR) begin
				count_q <= '0;
			end else if (in_fire && cmd == CMD_APPEND && count_q < CW'(MAX_ENTRIES)) begin
				count_q <= count_q + CW'(1);
			end
			if (in_fire && cmd == CMD_PICK) begin
				first_q <= 1'b1;
			end else if (state_q == S_SCAN) begin
				first_q <= 1'b0;
			end
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan datapath
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire && cmd == CMD_PICK) begin
			pos_q       <= pos_ext[AW-1:0];
			cmp_addr_q  <= pos_ext[AW-1:0];
			idx_q       <= pos_ext[CW-1:0] + CW'(1);
			res_found_q <= 1'b0;
			res_tag_q   <= '0;
		end
		if (state_q == S_SCAN) begin
			if (take_best) begin
				best_idx_q   <= cmp_addr_q;
				best_tag_q   <= rd_tag_q;
				best_score_q <= rd_score_q;
			end
			if (first_q) begin
				held_tag_q   <= rd_tag_q;
				held_score_q <= rd_score_q;
			end
			if (more) begin
				cmp_addr_q <= idx_q[AW-1:0];
				idx_q      <= idx_q + CW'(1);
			end
		end
		if (state_q == S_SWAP_A) begin
			res_found_q <= 1'b1;
			res_tag_q   <= best_tag_q;
		end
		if (state_q == S_RESULT && out_free) begin
			found_q      <= res_found_q;
			picked_tag_q <= res_tag_q;
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> idx_q <= count_q)
		else $error("scan index beyond entry count");

	a_swap_needed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SWAP_B |-> best_idx_q != pos_q && $past(state_q) == S_SWAP_A)
		else $error("second swap write without a distinct best entry");

	a_not_found_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !found_q |-> picked_tag_q == '0)
		else $error("not found beat carries a tag");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && in_valid && cmd == CMD_PICK |=> in_stall)
		else $error("pick accepted without going busy");

endmodule
